// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the marker size checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked assertion, disabled while reset is held.
`define JMSC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define JMSC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define JMSC_ASSERT(label, clk, rst, prop, msg)
`define JMSC_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ----- rtl/core/jmsc_pkg.sv -----
// ----------------------------------------------------------------------------
// jmsc_pkg
// Marker codes, frame header offsets, register indexes and shared types.
// ----------------------------------------------------------------------------
package jmsc_pkg;

  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_SOI    = 8'hD8;
  localparam logic [7:0] MARK_EOI    = 8'hD9;
  localparam logic [7:0] MARK_SOF0   = 8'hC0;

  // Byte offsets inside the frame header, counting the FF of FF C0 as zero.
  localparam logic [3:0] OFS_HEIGHT_HI = 4'd5;
  localparam logic [3:0] OFS_HEIGHT_LO = 4'd6;
  localparam logic [3:0] OFS_WIDTH_HI  = 4'd7;
  localparam logic [3:0] OFS_WIDTH_LO  = 4'd8;
  localparam logic [3:0] OFS_LAST      = 4'd8;
  localparam logic [3:0] OFS_MARKER    = 4'd1;

  localparam logic [15:0] MIN_DIM_RESET = 16'd800;
  localparam logic [15:0] MAX_DIM_RESET = 16'd4095;

  typedef enum logic {
    REG_MIN_DIMENSION = 1'b0,
    REG_MAX_DIMENSION = 1'b1
  } reg_index_t;

  // What the scan leaves behind at the end of one file.
  typedef struct packed {
    logic        start_seen;
    logic        end_seen;
    logic        first_byte_zero;
    logic [15:0] width_value;
    logic [15:0] height_value;
  } frame_summary_t;

endpackage

// ----- rtl/core/jmsc_scanner.sv -----
// ----------------------------------------------------------------------------
// jmsc_scanner
// Byte-wise marker scan and frame header capture; registers a summary per file.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jmsc_scanner (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              data_byte,
  input  logic                    last_byte,
  output logic                    sum_valid,
  input  logic                    sum_ready,
  output jmsc_pkg::frame_summary_t summary
);
  import jmsc_pkg::*;

  logic        previous_was_ff;
  logic        at_first_byte;
  logic        first_byte_zero;
  logic        start_seen;
  logic        end_seen;
  logic        frame_marker_seen;
  logic [3:0]  frame_byte_offset;
  logic [15:0] height_value;
  logic [15:0] width_value;

  logic        first_byte_zero_next;
  logic        start_seen_next;
  logic        end_seen_next;
  logic        frame_marker_seen_next;
  logic [3:0]  frame_byte_offset_next;
  logic [15:0] height_value_next;
  logic [15:0] width_value_next;
  logic        take;

  assign in_ready = !sum_valid || sum_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    first_byte_zero_next   = at_first_byte ? (data_byte == 8'd0) : first_byte_zero;
    start_seen_next        = start_seen;
    end_seen_next          = end_seen;
    frame_marker_seen_next = frame_marker_seen;
    frame_byte_offset_next = frame_byte_offset;
    height_value_next      = height_value;
    width_value_next       = width_value;

    // Header bytes that follow an SOF0 marker found on an earlier byte.
    if (frame_marker_seen && frame_byte_offset < OFS_LAST) begin
      frame_byte_offset_next = frame_byte_offset + 4'd1;
      unique case (frame_byte_offset_next)
        OFS_HEIGHT_HI: height_value_next[15:8] = data_byte;
        OFS_HEIGHT_LO: height_value_next[7:0]  = data_byte;
        OFS_WIDTH_HI:  width_value_next[15:8]  = data_byte;
        OFS_WIDTH_LO:  width_value_next[7:0]   = data_byte;
        default: ;
      endcase
    end

    if (previous_was_ff) begin
      if (start_seen && data_byte == MARK_EOI) end_seen_next = 1'b1;
      if (!start_seen && data_byte == MARK_SOI) start_seen_next = 1'b1;
      if (!frame_marker_seen && data_byte == MARK_SOF0) begin
        frame_marker_seen_next = 1'b1;
        frame_byte_offset_next = OFS_MARKER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_was_ff   <= 1'b0;
      at_first_byte     <= 1'b1;
      first_byte_zero   <= 1'b0;
      start_seen        <= 1'b0;
      end_seen          <= 1'b0;
      frame_marker_seen <= 1'b0;
      frame_byte_offset <= 4'd0;
      height_value      <= 16'd0;
      width_value       <= 16'd0;
      sum_valid         <= 1'b0;
    end else begin
      if (sum_ready) sum_valid <= 1'b0;
      if (take) begin
        if (last_byte) begin
          // The file ends here: hand over the summary and start a fresh file.
          sum_valid                    <= 1'b1;
          summary.start_seen           <= start_seen_next;
          summary.end_seen             <= end_seen_next;
          summary.first_byte_zero      <= first_byte_zero_next;
          summary.width_value          <= width_value_next;
          summary.height_value         <= height_value_next;
          previous_was_ff   <= 1'b0;
          at_first_byte     <= 1'b1;
          first_byte_zero   <= 1'b0;
          start_seen        <= 1'b0;
          end_seen          <= 1'b0;
          frame_marker_seen <= 1'b0;
          frame_byte_offset <= 4'd0;
          height_value      <= 16'd0;
          width_value       <= 16'd0;
        end else begin
          previous_was_ff   <= (data_byte == MARK_PREFIX);
          at_first_byte     <= 1'b0;
          first_byte_zero   <= first_byte_zero_next;
          start_seen        <= start_seen_next;
          end_seen          <= end_seen_next;
          frame_marker_seen <= frame_marker_seen_next;
          frame_byte_offset <= frame_byte_offset_next;
          height_value      <= height_value_next;
          width_value       <= width_value_next;
        end
      end
    end
  end

  `JMSC_ASSERT(a_last_restarts, clk, rst, (take && last_byte) |=> (at_first_byte && !start_seen), "last byte did not restart the scan")
  `JMSC_ASSERT(a_offset_tracks_marker, clk, rst, (frame_marker_seen || frame_byte_offset == 4'd0) && (frame_byte_offset <= OFS_LAST), "frame offset out of step with marker")
  `JMSC_ASSERT(a_end_needs_start, clk, rst, end_seen |-> start_seen, "end marker recorded without start marker")
  `JMSC_ASSERT(a_summary_held, clk, rst, (sum_valid && !sum_ready) |=> (sum_valid && $stable(summary)), "stalled summary changed")

endmodule

// ----- rtl/core/jmsc_judge.sv -----
// ----------------------------------------------------------------------------
// jmsc_judge
// Structure and dimension checks on a file summary; holds the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jmsc_judge (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     sum_valid,
  output logic                     sum_ready,
  input  jmsc_pkg::frame_summary_t summary,
  input  logic [15:0]              min_dimension,
  input  logic [15:0]              max_dimension,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     accepted,
  output logic                     structure_ok,
  output logic                     dimensions_ok,
  output logic [15:0]              image_width,
  output logic [15:0]              image_height
);
  import jmsc_pkg::*;

  logic s_ok;
  logic d_ok;

  assign sum_ready = !out_valid || out_ready;

  assign s_ok = summary.start_seen && summary.end_seen && !summary.first_byte_zero;
  assign d_ok = (summary.width_value  >= min_dimension) && (summary.width_value  <= max_dimension)
             && (summary.height_value >= min_dimension) && (summary.height_value <= max_dimension);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_ready) out_valid <= 1'b0;
      if (sum_valid && sum_ready) begin
        out_valid     <= 1'b1;
        accepted      <= s_ok && d_ok;
        structure_ok  <= s_ok;
        dimensions_ok <= d_ok;
        image_width   <= summary.width_value;
        image_height  <= summary.height_value;
      end
    end
  end

  `JMSC_ASSERT(a_accept_is_and, clk, rst, out_valid |-> (accepted == (structure_ok && dimensions_ok)), "accepted disagrees with the two checks")
  `JMSC_ASSERT(a_result_held, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(image_width) && $stable(image_height)), "stalled result changed")
  `JMSC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result register not empty after reset")

endmodule

// ----- rtl/core/jpeg_marker_size_checker.sv -----
// ----------------------------------------------------------------------------
// jpeg_marker_size_checker
// JPEG start/end marker check and SOF0 frame size check on a byte stream.
// ----------------------------------------------------------------------------
// The block takes one file byte per transfer, with last_byte set on the final
// byte, and accepts a byte on every clock cycle while in_ready is high. For
// each file it returns one result, once the last byte has passed through the
// file summary register and the result register: structure_ok says an FF D8
// start pair was found and an FF D9 end pair came after it, with a nonzero
// first byte; image_width and image_height come from the first FF C0 pair in
// the file (bytes 5..6 height, 7..8 width, big-endian), with missing bytes read
// as zero; dimensions_ok says both lie within min_dimension..max_dimension
// inclusive; accepted is both checks together. The rate of one byte per cycle
// is set by the scan registers, which update on every byte taken; a file
// summary register and the result register sit behind them, so the bytes of
// the next file keep flowing while one result waits, and the byte channel
// stalls only once a second file summary is waiting behind that result as well.
// Register 0 is min_dimension (reset 800) and register 1 is max_dimension
// (reset 4095); they are written through cfg_write, cfg_index and cfg_data.
// ----------------------------------------------------------------------------
module jpeg_marker_size_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        accepted,
  output logic        structure_ok,
  output logic        dimensions_ok,
  output logic [15:0] image_width,
  output logic [15:0] image_height
);
  import jmsc_pkg::*;

  logic [15:0]    min_dimension;
  logic [15:0]    max_dimension;
  logic           sum_valid;
  logic           sum_ready;
  frame_summary_t summary;

  // Configuration registers. Writes are expected only while the block is idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_dimension <= MIN_DIM_RESET;
      max_dimension <= MAX_DIM_RESET;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_MIN_DIMENSION: min_dimension <= cfg_data;
        REG_MAX_DIMENSION: max_dimension <= cfg_data;
        default: ;
      endcase
    end
  end

  // Scan stage: marker search and header capture, one byte per cycle while in_ready is high.
  jmsc_scanner u_scanner (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .summary   (summary)
  );

  // Check stage: structure and bounds checks and the result register.
  jmsc_judge u_judge (
    .clk           (clk),
    .rst           (rst),
    .sum_valid     (sum_valid),
    .sum_ready     (sum_ready),
    .summary       (summary),
    .min_dimension (min_dimension),
    .max_dimension (max_dimension),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .accepted      (accepted),
    .structure_ok  (structure_ok),
    .dimensions_ok (dimensions_ok),
    .image_width   (image_width),
    .image_height  (image_height)
  );

endmodule
